/* rtl/core/bh_pkg.sv */
// ----------------------------------------------------------------------------
// bh_pkg
// Shared types and constants for the byte histogram engine.
// ----------------------------------------------------------------------------
package bh_pkg;

  localparam int INDEX_BITS = 8;
  localparam int COUNT_BITS = 32;
  localparam int BIN_TOTAL  = 1 << INDEX_BITS;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef logic [INDEX_BITS-1:0] bin_idx_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
    logic       first_of_set;
  } hist_in_t;

  typedef struct packed {
    logic [7:0]  bin_number;
    logic [31:0] bin_count;
  } hist_out_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } bh_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic write_bin;
  } bh_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_read;
  } bh_status_t;

endpackage

/* rtl/core/bh_datapath.sv */
// ----------------------------------------------------------------------------
// bh_datapath
// Bin store, valid bits and the increment path of the histogram.
// ----------------------------------------------------------------------------
module bh_datapath (
  input  logic              clk,
  input  logic              rst,
  input  bh_pkg::hist_in_t  item,
  input  bh_pkg::bh_cmd_t   cmd,
  output bh_pkg::bh_status_t status,
  output bh_pkg::hist_out_t result
);
  import bh_pkg::*;

  count_t              mem [BIN_TOTAL];
  count_t              rdata;
  logic [BIN_TOTAL-1:0] valid;
  bin_idx_t            addr;
  logic                kind;
  bin_idx_t            item_bin;
  count_t              cur_count;

  assign item_bin = bin_idx_t'(item.byte_value);

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr <= item_bin;
      kind <= item.kind;
    end
  end

  // store: read on load, write back on update
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rdata <= mem[item_bin];
    end
    if (cmd.write_bin) begin
      mem[addr] <= cur_count + count_t'(1);
    end
  end

  // entry not valid reads as zero; a marked data item drops the whole set
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.load && item.kind == KIND_DATA && item.first_of_set) begin
      valid <= '0;
    end else if (cmd.write_bin) begin
      valid[addr] <= 1'b1;
    end
  end

  assign cur_count = valid[addr] ? rdata : '0;

  assign status.is_read    = (kind == KIND_READ);
  assign result.bin_number = 8'(addr);
  assign result.bin_count  = 32'(cur_count);

endmodule

/* rtl/core/bh_ctrl.sv */
// ----------------------------------------------------------------------------
// bh_ctrl
// Sequencer for the histogram: accept, then update or reply.
// ----------------------------------------------------------------------------
module bh_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  bh_pkg::bh_status_t  status,
  output bh_pkg::bh_cmd_t     cmd,
  output logic                busy,
  output logic                done
);
  import bh_pkg::*;

  bh_state_t state;
  bh_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.load      = 1'b0;
    cmd.write_bin = 1'b0;
    busy          = 1'b0;
    done          = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd.load = start;
      end
      ST_EXEC: begin
        busy          = 1'b1;
        cmd.write_bin = !status.is_read;
        done          = status.is_read;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/core/byte_histogram.sv */
// ----------------------------------------------------------------------------
// byte_histogram
// 256-bin byte histogram engine with clear-on-new-set and bin readback.
// ----------------------------------------------------------------------------
// For every item, the accept cycle issues the bin store read, and the next
// cycle (busy high) either writes back the incremented count for a data item
// or presents the count for a read item on result with done high for that
// one cycle. The registered read of the single-port bin store is why the
// work is split this way. The receiver cannot stall: done is a strobe and
// result is only valid while it is high. A data item with first_of_set high
// empties every bin at once (valid bits in flops) before its own byte is
// counted; first_of_set on a read item is ignored. Counts wrap at 2^32. The
// store is empty right after reset, with no clearing pass.
// ----------------------------------------------------------------------------
module byte_histogram (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  bh_pkg::hist_in_t  item,
  output logic              busy,
  output logic              done,
  output bh_pkg::hist_out_t result
);
  import bh_pkg::*;

  bh_cmd_t    cmd;
  bh_status_t status;

  // sequencer
  bh_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // bin store and increment path
  bh_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

endmodule

/* rtl/core/bh_checker.sv */
// ----------------------------------------------------------------------------
// bh_checker
// Port-level timing checks for the byte histogram, bound to the top level.
// ----------------------------------------------------------------------------
module bh_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // an accepted item always occupies the engine for the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // a result only appears while an item is in work
  a_done_in_work: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("done outside of work");

  // busy lasts one cycle
  a_busy_one: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  // a result follows directly on an accepted item
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("done without an accepted item");

endmodule

bind byte_histogram bh_checker u_bh_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

/* bench/hist_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hist_checker
// Watches the item and result channels of byte_histogram, keeps its own copy
// of the bin counts and compares every returned bin against it.
// ----------------------------------------------------------------------------
module hist_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  bh_pkg::hist_in_t  item,
  input  logic              done,
  input  bh_pkg::hist_out_t result,
  output int                errors,
  output int                pending
);
  import bh_pkg::*;

  count_t    bin_tally [BIN_TOTAL];
  hist_out_t bin_reads_due [$];
  int        fail_count = 0;

  // Data items bump their bin (after a clear when they open a set); read
  // items queue the count they must return. The mark is ignored on reads.
  function automatic void histogram_step(hist_in_t it);
    bin_idx_t  idx;
    hist_out_t want;
    idx = it.byte_value[INDEX_BITS-1:0];
    if (it.kind == KIND_DATA) begin
      if (it.first_of_set) begin
        foreach (bin_tally[i]) bin_tally[i] = '0;
      end
      bin_tally[idx] = bin_tally[idx] + 1'b1;
    end else begin
      want.bin_number = 8'(idx);
      want.bin_count  = 32'(bin_tally[idx]);
      bin_reads_due.push_back(want);
    end
  endfunction

  always @(posedge clk) begin
    hist_out_t want;
    if (rst) begin
      foreach (bin_tally[i]) bin_tally[i] = '0;
      bin_reads_due.delete();
    end else begin
      if (done) begin
        if (bin_reads_due.size() == 0) begin
          $error("unexpected result: bin_number %0d bin_count %0d",
                 result.bin_number, result.bin_count);
          fail_count++;
        end else begin
          want = bin_reads_due.pop_front();
          if (result.bin_number !== want.bin_number) begin
            $error("bin_number: expected %0d, got %0d", want.bin_number,
                   result.bin_number);
            fail_count++;
          end
          if (result.bin_count !== want.bin_count) begin
            $error("bin_count: expected %0d, got %0d", want.bin_count,
                   result.bin_count);
            fail_count++;
          end
        end
      end
      if (start && !busy) histogram_step(item);
    end
    errors  <= fail_count;
    pending <= bin_reads_due.size();
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for byte_histogram: directed corner items, then random
// data sets with interleaved bin reads, sent in bursts with random gaps.
// ----------------------------------------------------------------------------
module tb_top;
  import bh_pkg::*;

  localparam int RANDOM_ITEMS = 900;
  // No item or result for this many cycles means the block is stuck. The
  // longest legal quiet stretch is a sender gap plus the busy state of an item.
  localparam int STALL_LIMIT  = 200;

  logic      clk;
  logic      rst;
  logic      start;
  hist_in_t  item;
  logic      busy;
  logic      done;
  hist_out_t result;
  int        errors;
  int        pending;

  // Stimulus bookkeeping
  int        sent = 0;
  int        burst_left = 40;   // directed part goes out back to back
  int        quiet_cycles = 0;
  logic [7:0] last_byte = '0;
  logic [7:0] focus_base = '0;
  logic       focus_wide = 1'b1;

  byte_histogram u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  hist_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .item    (item),
    .done    (done),
    .result  (result),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Bytes for the current set: either anywhere in 0..255, or packed into
  // four neighboring bins so their counts climb.
  function automatic logic [7:0] pick_byte();
    if (focus_wide) return 8'($urandom);
    return focus_base + 8'($urandom_range(0, 3));
  endfunction

  // Send one item. Inputs move on the falling edge; the item is taken at
  // the first rising edge with busy low. Bursts mostly end in a random idle
  // gap, during which the item bus carries junk that must be ignored.
  task automatic send_item(logic k, logic [7:0] b, logic mark);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(30, 80);   // long stretch, no idling
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 16);
        gap = $urandom_range(1, 6);
      end
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
        item  <= hist_in_t'(10'($urandom));
      end
    end
    burst_left--;
    @(negedge clk);
    start <= 1'b1;
    item  <= '{kind: k, byte_value: b, first_of_set: mark};
    @(posedge clk);
    while (busy) @(posedge clk);
    if (k == KIND_DATA) last_byte = b;
    sent++;
  endtask

  // Hold off until every outstanding read has come back.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Watchdog: counts cycles with neither an item nor a result accepted.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int roll;
    int set_len;
    rst   = 1'b1;
    start = 1'b0;
    item  = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty store after reset, both ends of the byte range
    send_item(KIND_READ, 8'h00, 1'b0);
    send_item(KIND_READ, 8'hFF, 1'b0);
    // new set, then counting into the end bins and an alternating pattern
    send_item(KIND_DATA, 8'h00, 1'b1);
    send_item(KIND_DATA, 8'hFF, 1'b0);
    send_item(KIND_DATA, 8'hFF, 1'b0);
    send_item(KIND_DATA, 8'hAA, 1'b0);
    send_item(KIND_DATA, 8'h55, 1'b0);
    // mark on a read is ignored: bins must survive
    send_item(KIND_READ, 8'hFF, 1'b1);
    send_item(KIND_READ, 8'h00, 1'b0);
    send_item(KIND_READ, 8'hAA, 1'b1);
    // same byte back to back, read right behind the last write
    send_item(KIND_DATA, 8'h80, 1'b0);
    send_item(KIND_DATA, 8'h80, 1'b0);
    send_item(KIND_DATA, 8'h80, 1'b0);
    send_item(KIND_READ, 8'h80, 1'b0);
    // marked byte opens a fresh set: old bins read zero
    send_item(KIND_DATA, 8'h55, 1'b1);
    send_item(KIND_READ, 8'hFF, 1'b0);
    send_item(KIND_READ, 8'h55, 1'b0);
    send_item(KIND_READ, 8'h80, 1'b0);
    // marked byte repeating the previous set's only byte
    send_item(KIND_DATA, 8'h55, 1'b1);
    send_item(KIND_READ, 8'h55, 1'b0);
    // no further marked byte: counts stay put across idle time
    drain();
    send_item(KIND_READ, 8'h55, 1'b0);
    send_item(KIND_READ, 8'h7F, 1'b1);

    // Random: mostly well-formed sets (marked first byte, data, reads of
    // recent bins), some sets continuing the previous one, rare stray marks.
    sent = 0;
    burst_left = 0;
    while (sent < RANDOM_ITEMS) begin
      focus_wide = ($urandom_range(0, 2) == 0);
      focus_base = 8'($urandom);
      set_len    = $urandom_range(1, 60);
      send_item(KIND_DATA, pick_byte(), ($urandom_range(0, 9) != 0));
      for (int n = 1; n < set_len; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 65) send_item(KIND_DATA, pick_byte(), (roll < 2));
        else if (roll < 80) send_item(KIND_READ, last_byte, 1'($urandom));
        else if (roll < 95) send_item(KIND_READ, pick_byte(), 1'($urandom));
        else send_item(KIND_READ, 8'($urandom), 1'($urandom));
      end
      repeat ($urandom_range(1, 4)) send_item(KIND_READ, pick_byte(), 1'($urandom));
      if ($urandom_range(0, 7) == 0) drain();
    end

    drain();
    repeat (4) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/bh_pkg.sv
rtl/core/bh_datapath.sv
rtl/core/bh_ctrl.sv
rtl/core/byte_histogram.sv
rtl/core/bh_checker.sv
bench/hist_checker.sv
bench/tb_top.sv
